// ===== design/cfs_pkg.sv =====
// shared types, constants and sine/cosine table construction for the frequency shifter
package cfs_pkg;

	localparam int TableSize   = 4096;
	localparam int PhaseW      = 12;
	localparam int QuarterW    = PhaseW - 2;
	localparam int QuarterDepth = TableSize / 4;
	localparam int SampleW     = 16;
	localparam int StepW       = 13;
	localparam int TrigW       = SampleW - 1;

	// register byte addresses
	localparam logic [1:0] AddrShiftStep = 2'd0;

	localparam longint Q30One   = 64'sd1 << 30;
	localparam longint HalfPiQ30 = 64'sd1686629713;

	typedef logic [2*TrigW-1:0] rom_word_t;
	typedef rom_word_t rom_arr_t [QuarterDepth];

	// payload of stage one handed to the mixer
	typedef struct packed {
		logic [1:0]                quad;
		logic [TrigW-1:0]          sin_mag;
		logic [TrigW-1:0]          cos_mag;
		logic signed [SampleW-1:0] in_i;
		logic signed [SampleW-1:0] in_q;
	} mix_in_t;

	function automatic longint clamp_unit(input longint v);
		longint r;
		r = v;
		if (v < 0) r = 0;
		if (v > Q30One) r = Q30One;
		return r;
	endfunction

	function automatic longint to_sample(input longint v30);
		longint full;
		longint s;
		full = (64'sd1 <<< (SampleW - 1)) - 1;
		s = (v30 * (64'sd1 <<< (SampleW - 1)) + (64'sd1 <<< 29)) >>> 30;
		if (s > full) s = full;
		return s;
	endfunction

	// one quarter-wave entry: sin in the upper half, cos in the lower half
	function automatic rom_word_t quarter_entry(input int idx);
		longint th;
		longint x2;
		longint t;
		longint s;
		longint c;
		longint sv;
		longint cv;
		th = (longint'(idx) * 4 * HalfPiQ30 + TableSize / 2) / TableSize;
		x2 = (th * th) >>> 30;
		// taylor series for sine, horner form
		t = Q30One;
		t = Q30One - ((x2 * t) >>> 30) / 156;
		t = Q30One - ((x2 * t) >>> 30) / 110;
		t = Q30One - ((x2 * t) >>> 30) / 72;
		t = Q30One - ((x2 * t) >>> 30) / 42;
		t = Q30One - ((x2 * t) >>> 30) / 20;
		t = Q30One - ((x2 * t) >>> 30) / 6;
		s = clamp_unit((th * t) >>> 30);
		// cosine, negative partial terms held at zero
		t = Q30One;
		t = Q30One - ((x2 * ((t < 0) ? 64'sd0 : t)) >>> 30) / 182;
		t = Q30One - ((x2 * ((t < 0) ? 64'sd0 : t)) >>> 30) / 132;
		t = Q30One - ((x2 * ((t < 0) ? 64'sd0 : t)) >>> 30) / 90;
		t = Q30One - ((x2 * ((t < 0) ? 64'sd0 : t)) >>> 30) / 56;
		t = Q30One - ((x2 * ((t < 0) ? 64'sd0 : t)) >>> 30) / 30;
		t = Q30One - ((x2 * ((t < 0) ? 64'sd0 : t)) >>> 30) / 12;
		t = Q30One - ((x2 * ((t < 0) ? 64'sd0 : t)) >>> 30) / 2;
		c = clamp_unit(t);
		sv = to_sample(s);
		cv = to_sample(c);
		return {sv[TrigW-1:0], cv[TrigW-1:0]};
	endfunction

	function automatic rom_arr_t build_rom();
		rom_arr_t arr;
		for (int k = 0; k < QuarterDepth; k++) begin
			arr[k] = quarter_entry(k);
		end
		return arr;
	endfunction

endpackage

// ===== design/cfs_rom.sv =====
// quarter-wave sine/cosine table with registered read
module cfs_rom
	import cfs_pkg::*;
(
	input  logic                clk,
	input  logic                rd_en,
	input  logic [QuarterW-1:0] rd_addr,
	output rom_word_t           rd_data
);

	localparam rom_arr_t RomInit = build_rom();

	rom_word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= RomInit[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/cfs_mixer.sv =====
// complex multiply by the table phasor, then round and saturate, two register stages
module cfs_mixer
	import cfs_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  mix_in_t                    in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SampleW-1:0]  out_i,
	output logic signed [SampleW-1:0]  out_q
);

	localparam int ProdW = 2 * SampleW;
	localparam int AccW  = ProdW + 1;
	localparam int RndW  = AccW + 1;
	localparam int ShW   = RndW - (SampleW - 1);

	logic                      v_s2;
	logic                      v_s3;
	logic                      en_s2;
	logic                      en_s3;
	logic signed [SampleW-1:0] cs;
	logic signed [SampleW-1:0] sn;
	logic signed [SampleW-1:0] sin_v;
	logic signed [SampleW-1:0] cos_v;
	logic signed [ProdW-1:0]   p_ic_s2;
	logic signed [ProdW-1:0]   p_qs_s2;
	logic signed [ProdW-1:0]   p_is_s2;
	logic signed [ProdW-1:0]   p_qc_s2;
	logic signed [AccW-1:0]    acc_i;
	logic signed [AccW-1:0]    acc_q;
	logic signed [SampleW-1:0] sat_i;
	logic signed [SampleW-1:0] sat_q;
	logic signed [SampleW-1:0] out_i_s3;
	logic signed [SampleW-1:0] out_q_s3;

	function automatic logic signed [SampleW-1:0] round_sat(input logic signed [AccW-1:0] a);
		logic signed [RndW-1:0] rnd;
		logic signed [ShW-1:0]  sh;
		logic signed [ShW-1:0]  hi;
		logic signed [ShW-1:0]  lo;
		logic signed [SampleW-1:0] r;
		rnd = RndW'(a) + (RndW'(1) <<< (SampleW - 2));
		sh  = ShW'(rnd >>> (SampleW - 1));
		hi  = ShW'({1'b0, {(SampleW - 1){1'b1}}});
		lo  = -hi - ShW'(1);
		if (sh > hi) begin
			r = hi[SampleW-1:0];
		end else if (sh < lo) begin
			r = lo[SampleW-1:0];
		end else begin
			r = sh[SampleW-1:0];
		end
		return r;
	endfunction

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign in_ready = en_s2;

	assign sin_v = $signed({1'b0, in_data.sin_mag});
	assign cos_v = $signed({1'b0, in_data.cos_mag});

	// quadrant swaps and negates the first-quadrant values
	always_comb begin
		unique case (in_data.quad)
			2'd0: begin cs = cos_v;  sn = sin_v;  end
			2'd1: begin cs = -sin_v; sn = cos_v;  end
			2'd2: begin cs = -cos_v; sn = -sin_v; end
			default: begin cs = sin_v; sn = -cos_v; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s2) v_s2 <= in_valid;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			p_ic_s2 <= in_data.in_i * cs;
			p_qs_s2 <= in_data.in_q * sn;
			p_is_s2 <= in_data.in_i * sn;
			p_qc_s2 <= in_data.in_q * cs;
		end
	end

	assign acc_i = AccW'(p_ic_s2) - AccW'(p_qs_s2);
	assign acc_q = AccW'(p_is_s2) + AccW'(p_qc_s2);
	assign sat_i = round_sat(acc_i);
	assign sat_q = round_sat(acc_q);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			out_i_s3 <= sat_i;
			out_q_s3 <= sat_q;
		end
	end

	assign out_valid = v_s3;
	assign out_i     = out_i_s3;
	assign out_q     = out_q_s3;

endmodule

// ===== design/complex_frequency_shifter_top.sv =====
// top level: register port, phase accumulator, table lookup stage and mixer
// an accepted item passes the stage-one, product and output registers (three register stages)
// throughput: one item per cycle unless stalled; phase add and table read sit in the first stage
// ready chains back through the stages, bubbles are absorbed, so input is taken while a result waits
// reset (arst_n low) clears phase index, shift_step and all stage valids; table is constant
module complex_frequency_shifter_top
	import cfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // in_i [15:0], in_q [31:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // out_i [15:0], out_q [31:16]
);

	logic signed [StepW-1:0]   step_q;
	logic [PhaseW-1:0]         phase_q;
	logic                      v_s1;
	logic                      take;
	logic                      mix_ready;
	logic [1:0]                quad_s1;
	logic signed [SampleW-1:0] in_i_s1;
	logic signed [SampleW-1:0] in_q_s1;
	rom_word_t                 rom_data;
	mix_in_t                   mix_in;
	logic signed [SampleW-1:0] res_i;
	logic signed [SampleW-1:0] res_q;

	assign pready = 1'b1;
	assign prdata = 32'(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (psel && penable && pwrite && paddr == AddrShiftStep) begin
			step_q <= pwdata[StepW-1:0];
		end
	end

	assign s_axis_tready = !v_s1 || mix_ready;
	assign take          = s_axis_tvalid && s_axis_tready;

	// low bits of the step are already the step modulo the table size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			v_s1    <= 1'b0;
		end else begin
			if (take) phase_q <= phase_q + step_q[PhaseW-1:0];
			if (s_axis_tready) v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			quad_s1 <= phase_q[PhaseW-1:PhaseW-2];
			in_i_s1 <= s_axis_tdata[SampleW-1:0];
			in_q_s1 <= s_axis_tdata[2*SampleW-1:SampleW];
		end
	end

	cfs_rom u_rom (
		.clk     (clk),
		.rd_en   (take),
		.rd_addr (phase_q[QuarterW-1:0]),
		.rd_data (rom_data)
	);

	assign mix_in.quad    = quad_s1;
	assign mix_in.sin_mag = rom_data[2*TrigW-1:TrigW];
	assign mix_in.cos_mag = rom_data[TrigW-1:0];
	assign mix_in.in_i    = in_i_s1;
	assign mix_in.in_q    = in_q_s1;

	cfs_mixer u_mixer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (mix_ready),
		.in_data   (mix_in),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_i     (res_i),
		.out_q     (res_q)
	);

	assign m_axis_tdata = {res_q, res_i};

`ifndef SYNTHESIS
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> phase_q == $past(phase_q + step_q[PhaseW-1:0]))
		else $error("phase did not advance by the step");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> phase_q == $past(phase_q))
		else $error("phase moved without an item");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready && !mix_ready && v_s1) |-> !s_axis_tready)
		else $error("input taken while pipeline full and stalled");
`endif

endmodule
